// ===== hw/rtl/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, widths, register indexes and the arctangent table of the
// closest-point sonifier.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int CoordW      = 18;
    localparam int CordicSteps = 16;
    localparam int PreShift    = 24;
    localparam int CorW        = CoordW + PreShift + 3;
    localparam int AccW        = 26;
    localparam int DistW       = (2 * CoordW > 36) ? 2 * CoordW : 36;
    localparam int RootW       = DistW / 2 + 8;
    localparam int DivW        = RootW + 22;
    localparam int DenW        = 27;
    localparam int StepW       = 5;
    localparam int CntW        = 6;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 17;

    localparam logic [15:0] Deg180Q8  = 16'd46080;
    localparam logic [22:0] Deg90Q16  = 23'd5898240;

    localparam logic [CfgIdxW-1:0] REG_PITCH_LO  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PITCH_HI  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ANGLE_LIM = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CENTER    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MIN_INTV  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MAX_INTV  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MIN_DIST  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_MAX_DIST  = 3'd7;

    typedef struct packed {
        logic             load_pt;
        logic             square;
        logic             compare;
        logic             cor_init;
        logic             cor_step;
        logic [StepW-1:0] step;
        logic             angle;
        logic             pitch_mul;
        logic             div_load;
        logic             div_sel;
        logic             div_step;
        logic             pitch_done;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             intv_mul;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_status;

    function automatic logic [21:0] atan_q16(input logic [StepW-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/cps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer: point intake, nearest-point update and the frame-end steps
// (CORDIC, pitch divide, square root, interval divide, output load).
// ----------------------------------------------------------------------------
module cps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cps_pkg::t_status i_status,
    output cps_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_CMP, S_CINIT, S_COR, S_ANG, S_PMUL, S_PLD, S_PDIV,
        S_PRES, S_SQI, S_SQRT, S_IMUL, S_ILD, S_IDIV, S_FIN
    } t_state;

    t_state                    r_state, n_state;
    logic [cps_pkg::CntW-1:0]  r_cnt, n_cnt;

    localparam logic [cps_pkg::CntW-1:0] CorLast  = cps_pkg::CntW'(cps_pkg::CordicSteps - 1);
    localparam logic [cps_pkg::CntW-1:0] DivLast  = cps_pkg::CntW'(cps_pkg::DivW - 1);
    localparam logic [cps_pkg::CntW-1:0] SqrtLast = cps_pkg::CntW'(cps_pkg::RootW - 1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step = r_cnt[cps_pkg::StepW-1:0];
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_pt = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state = i_status.last ? S_CINIT : S_IDLE;
            end
            S_CINIT: begin
                o_cmd.cor_init = 1'b1;
                n_cnt = '0;
                n_state = S_COR;
            end
            S_COR: begin
                o_cmd.cor_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CorLast) n_state = S_ANG;
            end
            S_ANG: begin
                o_cmd.angle = 1'b1;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.pitch_mul = 1'b1;
                n_state = S_PLD;
            end
            S_PLD: begin
                o_cmd.div_load = 1'b1;
                n_cnt = '0;
                n_state = S_PDIV;
            end
            S_PDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DivLast) n_state = S_PRES;
            end
            S_PRES: begin
                o_cmd.pitch_done = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SqrtLast) n_state = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.intv_mul = 1'b1;
                n_state = S_ILD;
            end
            S_ILD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = 1'b1;
                n_cnt = '0;
                n_state = S_IDIV;
            end
            S_IDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DivLast) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.div_sel = 1'b1;
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/cps_dp.sv =====
// ----------------------------------------------------------------------------
// cps_dp
// Datapath: settings, squared distance and nearest-point hold, CORDIC angle,
// shared restoring divider, digit-by-digit square root and the output stage.
// ----------------------------------------------------------------------------
module cps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cps_pkg::t_cmd                     i_cmd,
    output cps_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [cps_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [cps_pkg::CfgDataW-1:0]      i_cfg_wdata,
    input  logic signed [cps_pkg::CoordW-1:0] i_x_mm,
    input  logic signed [cps_pkg::CoordW-1:0] i_y_mm,
    input  logic signed [cps_pkg::CoordW-1:0] i_z_mm,
    input  logic                              i_last_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [15:0]                       o_pitch_hz,
    output logic signed [1:0]                 o_channel,
    output logic [15:0]                       o_interval_ms
);

    localparam int CW = cps_pkg::CoordW;

    logic [15:0] r_pitch_lo, r_pitch_hi, r_angle_lim, r_center, r_min_intv, r_max_intv;
    logic [16:0] r_min_dist, r_max_dist;

    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_last;
    logic [cps_pkg::DistW-1:0] r_sqx, r_sqy, r_sqz, r_best;
    logic signed [CW-1:0] r_bx, r_bz;

    logic signed [cps_pkg::CorW-1:0] r_cx, r_cy;
    logic signed [cps_pkg::AccW-1:0] r_acc;
    logic        r_xzero, r_zneg;
    logic [15:0] r_ang;
    logic signed [1:0] r_chan;

    logic signed [cps_pkg::DivW-3:0] r_prod;
    logic [cps_pkg::DivW-1:0]        r_num;
    logic [cps_pkg::DenW:0]          r_rem;
    logic [cps_pkg::DenW-1:0]        r_den;
    logic                            r_qneg;
    logic [15:0]                     r_pitch;

    logic [2*cps_pkg::RootW-1:0] r_sqv;
    logic [cps_pkg::RootW+1:0]   r_srem;
    logic [cps_pkg::RootW-1:0]   r_root;

    logic        r_valid;
    logic [15:0] r_out_pitch, r_out_intv;
    logic signed [1:0] r_out_chan;

    // squared distance
    logic [CW-1:0] ax, ay, az;
    logic [cps_pkg::DistW-1:0] dsq, rearm_sq;
    always_comb begin
        ax = r_x[CW-1] ? CW'(-r_x) : r_x;
        ay = r_y[CW-1] ? CW'(-r_y) : r_y;
        az = r_z[CW-1] ? CW'(-r_z) : r_z;
        dsq = r_sqx + r_sqy + r_sqz;
        rearm_sq = cps_pkg::DistW'(r_max_dist * r_max_dist);
    end

    // CORDIC
    logic [CW-1:0] bax, baz;
    logic signed [cps_pkg::CorW-1:0] dx, dy;
    logic signed [cps_pkg::AccW-1:0] atn;
    always_comb begin
        bax = r_bx[CW-1] ? CW'(-r_bx) : r_bx;
        baz = r_bz[CW-1] ? CW'(-r_bz) : r_bz;
        dx  = r_cy >>> i_cmd.step;
        dy  = r_cx >>> i_cmd.step;
        atn = cps_pkg::AccW'(cps_pkg::atan_q16(i_cmd.step));
    end

    // angle finish
    logic [22:0] accc;
    logic [15:0] a_rnd, ang_raw, ang_cl;
    always_comb begin
        if (r_acc < 0) accc = '0;
        else if (r_acc > $signed({3'b000, cps_pkg::Deg90Q16})) accc = cps_pkg::Deg90Q16;
        else accc = r_acc[22:0];
        a_rnd = 16'((24'(accc) + 24'd128) >> 8);
        if (r_xzero) ang_raw = r_zneg ? cps_pkg::Deg180Q8 : 16'd0;
        else ang_raw = r_zneg ? cps_pkg::Deg180Q8 - a_rnd : a_rnd;
        ang_cl = (ang_raw > r_angle_lim) ? r_angle_lim : ang_raw;
    end

    // divider load: N = 2n + d, D = 2d, floor(N / D)
    logic signed [cps_pkg::DivW:0] num_s;
    logic [cps_pkg::DenW-1:0]      den_s;
    logic signed [17:0]            span;
    always_comb begin
        span = $signed({1'b0, r_max_dist}) - $signed({1'b0, r_min_dist});
        if (i_cmd.div_sel) den_s = cps_pkg::DenW'({span[16:0], 9'd0});
        else den_s = cps_pkg::DenW'({r_angle_lim, 1'b0});
        num_s = $signed({{2{r_prod[cps_pkg::DivW-3]}}, r_prod, 1'b0})
              + $signed({1'b0, den_s[cps_pkg::DenW-1:1]});
    end

    logic [cps_pkg::DenW+1:0] rem2;
    logic [cps_pkg::DenW+1:0] rem_diff;
    always_comb begin
        rem2 = {r_rem, r_num[cps_pkg::DivW-1]};
        rem_diff = rem2 - {2'b00, r_den};
    end

    logic signed [cps_pkg::DivW+1:0] quot, res;
    always_comb begin
        quot = r_qneg ? -$signed({2'b00, r_num}) : $signed({2'b00, r_num});
        if (i_cmd.div_sel) res = quot + $signed({{(cps_pkg::DivW-14){1'b0}}, r_min_intv});
        else res = quot + $signed({{(cps_pkg::DivW-14){1'b0}}, r_pitch_lo});
    end

    function automatic logic [15:0] sat16(input logic signed [cps_pkg::DivW+1:0] v);
        logic [15:0] s;
        if (v < 0) s = 16'd0;
        else if (v > $signed((cps_pkg::DivW+2)'(65535))) s = 16'hFFFF;
        else s = v[15:0];
        return s;
    endfunction

    // square root step
    logic [cps_pkg::RootW+3:0] srem2, strial;
    always_comb begin
        srem2  = {r_srem, r_sqv[2*cps_pkg::RootW-1 -: 2]};
        strial = (cps_pkg::RootW+4)'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_lo  <= 16'd20;
            r_pitch_hi  <= 16'd20000;
            r_angle_lim <= 16'd46080;
            r_center    <= 16'd1280;
            r_min_intv  <= 16'd50;
            r_max_intv  <= 16'd5000;
            r_min_dist  <= 17'd0;
            r_max_dist  <= 17'd20000;
            r_best      <= cps_pkg::DistW'(36'd400000000);
            r_bx        <= '0;
            r_bz        <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cps_pkg::REG_PITCH_LO:  r_pitch_lo  <= i_cfg_wdata[15:0];
                    cps_pkg::REG_PITCH_HI:  r_pitch_hi  <= i_cfg_wdata[15:0];
                    cps_pkg::REG_ANGLE_LIM: r_angle_lim <= i_cfg_wdata[15:0];
                    cps_pkg::REG_CENTER:    r_center    <= i_cfg_wdata[15:0];
                    cps_pkg::REG_MIN_INTV:  r_min_intv  <= i_cfg_wdata[15:0];
                    cps_pkg::REG_MAX_INTV:  r_max_intv  <= i_cfg_wdata[15:0];
                    cps_pkg::REG_MIN_DIST:  r_min_dist  <= i_cfg_wdata;
                    cps_pkg::REG_MAX_DIST: begin
                        r_max_dist <= i_cfg_wdata;
                        r_best <= cps_pkg::DistW'(i_cfg_wdata * i_cfg_wdata);
                        r_bx <= '0;
                        r_bz <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.compare && dsq < r_best) begin
                r_best <= dsq;
                r_bx   <= r_x;
                r_bz   <= r_z;
            end
            if (i_cmd.finish) begin
                r_best  <= rearm_sq;
                r_bx    <= '0;
                r_bz    <= '0;
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_x <= i_x_mm;
            r_y <= i_y_mm;
            r_z <= i_z_mm;
            r_last <= i_last_point;
        end
        if (i_cmd.square) begin
            r_sqx <= cps_pkg::DistW'(ax * ax);
            r_sqy <= cps_pkg::DistW'(ay * ay);
            r_sqz <= cps_pkg::DistW'(az * az);
        end
        if (i_cmd.cor_init) begin
            r_cx    <= $signed(cps_pkg::CorW'({baz, {cps_pkg::PreShift{1'b0}}}));
            r_cy    <= $signed(cps_pkg::CorW'({bax, {cps_pkg::PreShift{1'b0}}}));
            r_acc   <= '0;
            r_xzero <= (r_bx == '0);
            r_zneg  <= r_bz[CW-1];
        end
        if (i_cmd.cor_step) begin
            if (!r_cy[cps_pkg::CorW-1]) begin
                r_cx  <= r_cx + dx;
                r_cy  <= r_cy - dy;
                r_acc <= r_acc + atn;
            end else begin
                r_cx  <= r_cx - dx;
                r_cy  <= r_cy + dy;
                r_acc <= r_acc - atn;
            end
        end
        if (i_cmd.angle) begin
            r_ang <= ang_cl;
            if (ang_cl < r_center) r_chan <= 2'sd0;
            else if (!r_bx[CW-1] && r_bx != '0) r_chan <= 2'sd1;
            else r_chan <= -2'sd1;
        end
        if (i_cmd.pitch_mul) begin
            r_prod <= (cps_pkg::DivW-2)'(($signed({1'b0, r_pitch_hi}) -
                      $signed({1'b0, r_pitch_lo})) * $signed({1'b0, r_angle_lim - r_ang}));
        end
        if (i_cmd.intv_mul) begin
            r_prod <= (cps_pkg::DivW-2)'(($signed({1'b0, r_max_intv}) -
                      $signed({1'b0, r_min_intv})) * $signed({1'b0, r_root}));
        end
        if (i_cmd.div_load) begin
            r_den  <= den_s;
            r_rem  <= '0;
            r_qneg <= num_s[cps_pkg::DivW];
            if (num_s[cps_pkg::DivW])
                r_num <= cps_pkg::DivW'(-num_s + $signed({1'b0, den_s}) - 1);
            else
                r_num <= num_s[cps_pkg::DivW-1:0];
        end
        if (i_cmd.div_step) begin
            if (!rem_diff[cps_pkg::DenW+1]) begin
                r_rem <= rem_diff[cps_pkg::DenW:0];
                r_num <= {r_num[cps_pkg::DivW-2:0], 1'b1};
            end else begin
                r_rem <= rem2[cps_pkg::DenW:0];
                r_num <= {r_num[cps_pkg::DivW-2:0], 1'b0};
            end
        end
        if (i_cmd.pitch_done) begin
            r_pitch <= (r_angle_lim == 16'd0) ? r_pitch_hi : sat16(res);
        end
        if (i_cmd.sqrt_init) begin
            r_sqv  <= (2*cps_pkg::RootW)'({r_best, 16'd0});
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sqv <= {r_sqv[2*cps_pkg::RootW-3:0], 2'b00};
            if (srem2 >= strial) begin
                r_srem <= (cps_pkg::RootW+2)'(srem2 - strial);
                r_root <= {r_root[cps_pkg::RootW-2:0], 1'b1};
            end else begin
                r_srem <= (cps_pkg::RootW+2)'(srem2);
                r_root <= {r_root[cps_pkg::RootW-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out_pitch <= r_pitch;
            r_out_chan  <= r_chan;
            r_out_intv  <= span[17] || span == '0 ? 16'hFFFF : sat16(res);
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_busy = r_valid && !i_ready;
    assign o_valid       = r_valid;
    assign o_pitch_hz    = r_out_pitch;
    assign o_channel     = r_out_chan;
    assign o_interval_ms = r_out_intv;

endmodule

// ===== hw/rtl/closest_point_sonifier.sv =====
// ----------------------------------------------------------------------------
// closest_point_sonifier
// Nearest-point search over a frame of 3-D points and frame-end sonification.
// ----------------------------------------------------------------------------
// A point passes intake, squaring and compare in the sequencer, which handles
// one point at a time. The point flagged last adds the frame-end work:
// 16 CORDIC steps, two restoring divides through one shared divider and a
// 26-step square root; the result then waits in the output register and
// the next point is taken while it waits.
module closest_point_sonifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [cps_pkg::CoordW-1:0] i_x_mm,
    input  logic signed [cps_pkg::CoordW-1:0] i_y_mm,
    input  logic signed [cps_pkg::CoordW-1:0] i_z_mm,
    input  logic                              i_last_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [15:0]                       o_pitch_hz,
    output logic signed [1:0]                 o_channel,
    output logic [15:0]                       o_interval_ms,
    input  logic                              i_cfg_we,
    input  logic [cps_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [cps_pkg::CfgDataW-1:0]      i_cfg_wdata
);

    cps_pkg::t_cmd    cmd;
    cps_pkg::t_status status;

    cps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cps_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_x_mm        (i_x_mm),
        .i_y_mm        (i_y_mm),
        .i_z_mm        (i_z_mm),
        .i_last_point  (i_last_point),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pitch_hz    (o_pitch_hz),
        .o_channel     (o_channel),
        .o_interval_ms (o_interval_ms)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest-point sonifier testbench
// Streams frames of 3-D points through the block under random handshake
// gaps, predicts the pitch, channel and interval of every frame end and
// compares each result against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
    logic [15:0]       pitch;
    logic signed [1:0] chan;
    logic [15:0]       intv;
} t_tone;

class t_sonifier_scoreboard;
    longint pitch_lo, pitch_hi, angle_lim, mid_band;
    longint min_intv, max_intv, min_dist, max_dist;
    longint best_dsq, best_x, best_z;
    t_tone  expected_tones[$];
    int     errors;
    longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

    function void rearm();
        best_dsq = max_dist * max_dist;
        best_x = 0;
        best_z = 0;
    endfunction

    function void reset_regs();
        pitch_lo = 20; pitch_hi = 20000; angle_lim = 46080; mid_band = 1280;
        min_intv = 50; max_intv = 5000; min_dist = 0; max_dist = 20000;
        errors = 0;
        rearm();
    endfunction

    function void write_reg(logic [cps_pkg::CfgIdxW-1:0] idx, logic [16:0] val);
        case (idx)
            cps_pkg::REG_PITCH_LO:  pitch_lo = longint'(val[15:0]);
            cps_pkg::REG_PITCH_HI:  pitch_hi = longint'(val[15:0]);
            cps_pkg::REG_ANGLE_LIM: angle_lim = longint'(val[15:0]);
            cps_pkg::REG_CENTER:    mid_band = longint'(val[15:0]);
            cps_pkg::REG_MIN_INTV:  min_intv = longint'(val[15:0]);
            cps_pkg::REG_MAX_INTV:  max_intv = longint'(val[15:0]);
            cps_pkg::REG_MIN_DIST:  min_dist = longint'(val);
            cps_pkg::REG_MAX_DIST:  begin max_dist = longint'(val); rearm(); end
            default: ;
        endcase
    endfunction

    function longint round_ratio(longint n, longint d);
        longint num, den, q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint bearing_q8(longint x, longint z);
        longint ax, az, cx, cy, dx, dy, acc, a;
        if (x == 0) return (z < 0) ? 46080 : 0;
        ax = (x < 0) ? -x : x;
        az = (z < 0) ? -z : z;
        cx = az <<< 24;
        cy = ax <<< 24;
        acc = 0;
        for (int i = 0; i < cps_pkg::CordicSteps && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; acc += atan_tab[i];
            end else begin
                cx -= dx; cy += dy; acc -= atan_tab[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > 5898240) acc = 5898240;
        a = (acc + 128) >>> 8;
        return (z < 0) ? 46080 - a : a;
    endfunction

    function longint sat16(longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    function void note_point(longint x, longint y, longint z, bit last);
        longint dsq, ang, pitch, intv, span;
        t_tone  t;
        dsq = x * x + y * y + z * z;
        if (dsq < best_dsq) begin
            best_dsq = dsq; best_x = x; best_z = z;
        end
        if (!last) return;
        ang = bearing_q8(best_x, best_z);
        if (ang > angle_lim) ang = angle_lim;
        if (angle_lim == 0) pitch = pitch_hi;
        else pitch = pitch_lo
                     + round_ratio((pitch_hi - pitch_lo) * (angle_lim - ang), angle_lim);
        if (ang < mid_band) t.chan = 2'sd0;
        else if (best_x > 0) t.chan = 2'sd1;
        else t.chan = -2'sd1;
        span = max_dist - min_dist;
        if (span <= 0) intv = 65535;
        else intv = min_intv + round_ratio((max_intv - min_intv) * int_sqrt(best_dsq << 16),
                                           span * 256);
        t.pitch = 16'(sat16(pitch));
        t.intv = 16'(sat16(intv));
        expected_tones.push_back(t);
        rearm();
    endfunction

    function void check_result(logic [15:0] pitch, logic signed [1:0] chan,
                               logic [15:0] intv);
        t_tone t;
        if (expected_tones.size() == 0) begin
            $display("%0t: unexpected result pitch %0d channel %0d interval %0d",
                     $time, pitch, chan, intv);
            errors++;
            return;
        end
        t = expected_tones.pop_front();
        if (pitch !== t.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, t.pitch, pitch);
            errors++;
        end
        if (chan !== t.chan) begin
            $display("%0t: channel expected %0d actual %0d", $time, t.chan, chan);
            errors++;
        end
        if (intv !== t.intv) begin
            $display("%0t: interval expected %0d actual %0d", $time, t.intv, intv);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int WatchLimit = 20000;
    localparam int SettleCycles = 300;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic signed [cps_pkg::CoordW-1:0] i_x_mm = '0;
    logic signed [cps_pkg::CoordW-1:0] i_y_mm = '0;
    logic signed [cps_pkg::CoordW-1:0] i_z_mm = '0;
    logic                              i_last_point = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic [15:0]                       o_pitch_hz;
    logic signed [1:0]                 o_channel;
    logic [15:0]                       o_interval_ms;
    logic                              i_cfg_we = 1'b0;
    logic [cps_pkg::CfgIdxW-1:0]       i_cfg_index = '0;
    logic [cps_pkg::CfgDataW-1:0]      i_cfg_wdata = '0;

    t_sonifier_scoreboard tones = new();
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    int  rx_hold = 0;
    int  quiet_cycles = 0;
    int  cur_max_dist = 20000;

    closest_point_sonifier DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tones.check_result(o_pitch_hz, o_channel, o_interval_ms);
            rx_hold = rx_gaps ? int'($urandom_range(0, 12)) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready = 1'b0;
        end else if (rx_hold > 0) begin
            i_ready = 1'b0;
            rx_hold--;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WatchLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_point(int x, int y, int z, bit last);
        int gap;
        gap = tx_gaps ? int'($urandom_range(0, 12)) : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_x_mm = cps_pkg::CoordW'(x);
        i_y_mm = cps_pkg::CoordW'(y);
        i_z_mm = cps_pkg::CoordW'(z);
        i_last_point = last;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        tones.note_point(longint'(i_x_mm), longint'(i_y_mm), longint'(i_z_mm), last);
    endtask

    // hold until every expected result is back and the block has settled
    task automatic drain();
        @(negedge i_clk) i_valid = 1'b0;
        while (tones.expected_tones.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [cps_pkg::CfgIdxW-1:0] idx,
                             logic [cps_pkg::CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        tones.write_reg(idx, val);
        if (idx == cps_pkg::REG_MAX_DIST) cur_max_dist = int'(val);
        @(negedge i_clk) i_cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_config();
        logic [16:0] md;
        write_reg(cps_pkg::REG_PITCH_LO, cps_pkg::CfgDataW'(pick16()));
        write_reg(cps_pkg::REG_PITCH_HI, cps_pkg::CfgDataW'(pick16()));
        case ($urandom_range(0, 3))
            0: write_reg(cps_pkg::REG_ANGLE_LIM, 17'd46080);
            1: write_reg(cps_pkg::REG_ANGLE_LIM, 17'd1);
            default: write_reg(cps_pkg::REG_ANGLE_LIM,
                               cps_pkg::CfgDataW'($urandom_range(1, 46080)));
        endcase
        write_reg(cps_pkg::REG_CENTER, cps_pkg::CfgDataW'(($urandom_range(0, 3) == 0)
                                        ? pick16() : $urandom_range(0, 46080)));
        write_reg(cps_pkg::REG_MIN_INTV, cps_pkg::CfgDataW'(pick16()));
        write_reg(cps_pkg::REG_MAX_INTV, cps_pkg::CfgDataW'(pick16()));
        case ($urandom_range(0, 5))
            0: md = 17'd1;
            1: md = 17'h1FFFF;
            2: md = 17'($urandom_range(0, 131071));
            default: md = 17'($urandom_range(100, 30000));
        endcase
        write_reg(cps_pkg::REG_MIN_DIST,
                  cps_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                                 : $urandom_range(0, md / 2)));
        write_reg(cps_pkg::REG_MAX_DIST, md);
    endtask

    function automatic int rand_coord();
        int lim;
        logic [17:0] raw;
        lim = cur_max_dist / 2;
        raw = 18'($urandom);
        case ($urandom_range(0, 11))
            0: return int'($signed(raw));
            1: return 0;
            2: return -131072;
            3: return 131071;
            default: return int'($urandom_range(0, 2 * lim)) - lim;
        endcase
    endfunction

    initial begin
        int n;
        tones.reset_regs();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        send_point(0, 0, 0, 1'b1);
        send_point(-131072, -131072, -131072, 1'b1);
        send_point(131071, 131071, 131071, 1'b1);
        send_point(0, 100, -5000, 1'b1);
        send_point(0, 0, 7000, 1'b1);
        send_point(3000, 0, 4000, 1'b0);
        send_point(-3000, 0, 4000, 1'b1);
        send_point(-4000, 200, -100, 1'b1);
        send_point(50, 0, 9000, 1'b0);
        send_point(8000, 0, 8000, 1'b1);
        send_point(1000, 1000, 1000, 1'b0);
        send_point(500, 500, 500, 1'b0);
        drain();
        write_reg(cps_pkg::REG_MAX_DIST, 17'd12000);
        send_point(20000, 0, 0, 1'b1);
        drain();
        write_reg(cps_pkg::REG_ANGLE_LIM, 17'd0);
        write_reg(cps_pkg::REG_MIN_DIST, 17'd12000);
        write_reg(cps_pkg::REG_PITCH_LO, 17'hFFFF);
        write_reg(cps_pkg::REG_PITCH_HI, 17'd0);
        send_point(700, 0, -800, 1'b1);
        drain();
        write_reg(cps_pkg::REG_ANGLE_LIM, 17'd46080);
        write_reg(cps_pkg::REG_CENTER, 17'hFFFF);
        write_reg(cps_pkg::REG_MIN_DIST, 17'd0);
        write_reg(cps_pkg::REG_MAX_DIST, 17'h1FFFF);
        write_reg(cps_pkg::REG_MIN_INTV, 17'hFFFF);
        write_reg(cps_pkg::REG_MAX_INTV, 17'd0);
        send_point(-90000, 0, 1, 1'b1);
        send_point(1, 0, 0, 1'b1);
        drain();
        write_reg(cps_pkg::REG_MAX_DIST, 17'd0);
        send_point(0, 0, 0, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            tx_gaps = (phase % 3) != 1;
            rx_gaps = (phase % 4) != 2;
            n = 0;
            while (n < 200) begin
                int len;
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_point(rand_coord(), rand_coord(), rand_coord(),
                                   1'($urandom_range(0, 1)));
                    else
                        send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
                    n++;
                end
                if (phase == 3 && n > 100 && n <= 112) begin
                    @(negedge i_clk) i_valid = 1'b0;
                    while (tones.expected_tones.size() != 0) @(posedge i_clk);
                end
            end
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
            drain();
        end

        if (tones.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== closest_point_sonifier.f =====
hw/rtl/cps_pkg.sv
hw/rtl/cps_ctrl.sv
hw/rtl/cps_dp.sv
hw/rtl/closest_point_sonifier.sv
bench/tb_top.sv
